FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion that reports with $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the active-low reset is asserted.
`define RIE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked at every clock edge, reset included.
`define RIE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/rie_pkg.sv
`timescale 1ns / 1ps

package rie_pkg;

    // Mnemonic codes carried in the func field.
    typedef enum logic [4:0] {
        FUNC_ADD     = 5'd0,
        FUNC_SUB     = 5'd1,
        FUNC_AND     = 5'd2,
        FUNC_OR      = 5'd3,
        FUNC_XOR     = 5'd4,
        FUNC_SLL     = 5'd5,
        FUNC_SRL     = 5'd6,
        FUNC_SRA     = 5'd7,
        FUNC_SLT     = 5'd8,
        FUNC_MUL     = 5'd9,
        FUNC_DIV     = 5'd10,
        FUNC_REM     = 5'd11,
        FUNC_ADDI    = 5'd12,
        FUNC_ANDI    = 5'd13,
        FUNC_ORI     = 5'd14,
        FUNC_LB      = 5'd15,
        FUNC_LH      = 5'd16,
        FUNC_LW      = 5'd17,
        FUNC_LD      = 5'd18,
        FUNC_SB      = 5'd19,
        FUNC_SH      = 5'd20,
        FUNC_SW      = 5'd21,
        FUNC_SD      = 5'd22,
        FUNC_JALR    = 5'd23,
        FUNC_BEQ     = 5'd24,
        FUNC_BNE     = 5'd25,
        FUNC_BLT     = 5'd26,
        FUNC_BGE     = 5'd27,
        FUNC_LUI     = 5'd28,
        FUNC_AUIPC   = 5'd29,
        FUNC_JAL     = 5'd30,
        FUNC_UNKNOWN = 5'd31
    } func_t;

    // Instruction formats; FMT_BAD marks a mnemonic that has no encoding.
    typedef enum logic [2:0] {
        FMT_R   = 3'd0,
        FMT_I   = 3'd1,
        FMT_S   = 3'd2,
        FMT_B   = 3'd3,
        FMT_U   = 3'd4,
        FMT_J   = 3'd5,
        FMT_BAD = 3'd6
    } fmt_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_RANGE   = 2'd1,
        STATUS_UNKNOWN = 2'd2
    } status_t;

    // Major opcodes.
    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_JAL    = 7'b1101111;

    // funct7 values for the alternate ALU ops and the multiply/divide group.
    localparam logic [6:0] F7_BASE   = 7'b0000000;
    localparam logic [6:0] F7_ALT    = 7'b0100000;
    localparam logic [6:0] F7_MULDIV = 7'b0000001;

    // One accepted request as held in the input register.
    typedef struct packed {
        logic [4:0]  func;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm_value;
        logic [31:0] pc;
        logic [31:0] target_addr;
    } item_t;

    // Encoding table entry for one mnemonic.
    typedef struct packed {
        fmt_t       fmt;
        logic [6:0] opc;
        logic [2:0] f3;
        logic [6:0] f7;
    } enc_entry_t;

    function automatic enc_entry_t enc_lookup(input func_t func);
        enc_entry_t e;
        e = '{fmt: FMT_BAD, opc: 7'd0, f3: 3'd0, f7: F7_BASE};
        unique case (func)
            FUNC_ADD:   e = '{fmt: FMT_R, opc: OP_REG, f3: 3'd0, f7: F7_BASE};
            FUNC_SUB:   e = '{fmt: FMT_R, opc: OP_REG, f3: 3'd0, f7: F7_ALT};
            FUNC_AND:   e = '{fmt: FMT_R, opc: OP_REG, f3: 3'd7, f7: F7_BASE};
            FUNC_OR:    e = '{fmt: FMT_R, opc: OP_REG, f3: 3'd6, f7: F7_BASE};
            FUNC_XOR:   e = '{fmt: FMT_R, opc: OP_REG, f3: 3'd4, f7: F7_BASE};
            FUNC_SLL:   e = '{fmt: FMT_R, opc: OP_REG, f3: 3'd1, f7: F7_BASE};
            FUNC_SRL:   e = '{fmt: FMT_R, opc: OP_REG, f3: 3'd5, f7: F7_BASE};
            FUNC_SRA:   e = '{fmt: FMT_R, opc: OP_REG, f3: 3'd5, f7: F7_ALT};
            FUNC_SLT:   e = '{fmt: FMT_R, opc: OP_REG, f3: 3'd2, f7: F7_BASE};
            FUNC_MUL:   e = '{fmt: FMT_R, opc: OP_REG, f3: 3'd0, f7: F7_MULDIV};
            FUNC_DIV:   e = '{fmt: FMT_R, opc: OP_REG, f3: 3'd4, f7: F7_MULDIV};
            FUNC_REM:   e = '{fmt: FMT_R, opc: OP_REG, f3: 3'd6, f7: F7_MULDIV};
            FUNC_ADDI:  e = '{fmt: FMT_I, opc: OP_IMM, f3: 3'd0, f7: F7_BASE};
            FUNC_ANDI:  e = '{fmt: FMT_I, opc: OP_IMM, f3: 3'd7, f7: F7_BASE};
            FUNC_ORI:   e = '{fmt: FMT_I, opc: OP_IMM, f3: 3'd6, f7: F7_BASE};
            FUNC_LB:    e = '{fmt: FMT_I, opc: OP_LOAD, f3: 3'd0, f7: F7_BASE};
            FUNC_LH:    e = '{fmt: FMT_I, opc: OP_LOAD, f3: 3'd1, f7: F7_BASE};
            FUNC_LW:    e = '{fmt: FMT_I, opc: OP_LOAD, f3: 3'd2, f7: F7_BASE};
            FUNC_LD:    e = '{fmt: FMT_I, opc: OP_LOAD, f3: 3'd3, f7: F7_BASE};
            FUNC_SB:    e = '{fmt: FMT_S, opc: OP_STORE, f3: 3'd0, f7: F7_BASE};
            FUNC_SH:    e = '{fmt: FMT_S, opc: OP_STORE, f3: 3'd1, f7: F7_BASE};
            FUNC_SW:    e = '{fmt: FMT_S, opc: OP_STORE, f3: 3'd2, f7: F7_BASE};
            FUNC_SD:    e = '{fmt: FMT_S, opc: OP_STORE, f3: 3'd3, f7: F7_BASE};
            FUNC_JALR:  e = '{fmt: FMT_I, opc: OP_JALR, f3: 3'd0, f7: F7_BASE};
            FUNC_BEQ:   e = '{fmt: FMT_B, opc: OP_BRANCH, f3: 3'd0, f7: F7_BASE};
            FUNC_BNE:   e = '{fmt: FMT_B, opc: OP_BRANCH, f3: 3'd1, f7: F7_BASE};
            FUNC_BLT:   e = '{fmt: FMT_B, opc: OP_BRANCH, f3: 3'd4, f7: F7_BASE};
            FUNC_BGE:   e = '{fmt: FMT_B, opc: OP_BRANCH, f3: 3'd5, f7: F7_BASE};
            FUNC_LUI:   e = '{fmt: FMT_U, opc: OP_LUI, f3: 3'd0, f7: F7_BASE};
            FUNC_AUIPC: e = '{fmt: FMT_U, opc: OP_AUIPC, f3: 3'd0, f7: F7_BASE};
            FUNC_JAL:   e = '{fmt: FMT_J, opc: OP_JAL, f3: 3'd0, f7: F7_BASE};
            default:    e = '{fmt: FMT_BAD, opc: 7'd0, f3: 3'd0, f7: F7_BASE};
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/core/rie_encode.sv
`timescale 1ns / 1ps

module rie_encode import rie_pkg::*; (
    input  item_t       item,
    output logic [31:0] machine_word,
    output status_t     status
);

    enc_entry_t  ent;
    logic [31:0] off;
    logic [31:0] imm;
    logic        imm12_ok;
    logic        imm20_ok;

    // Table lookup, branch and jump offset and immediate range checks.
    always_comb begin
        ent = enc_lookup(func_t'(item.func));
        off = item.target_addr - item.pc;
        imm = item.imm_value;
        // -2048..2047: bits 31..11 are all equal to the sign.
        imm12_ok = (&imm[31:11]) | ~(|imm[31:11]);
        // 0..1048575: nothing set above bit 19.
        imm20_ok = ~(|imm[31:20]);
    end

    // Field assembly per format; any error yields a zero word.
    always_comb begin
        machine_word = 32'd0;
        status       = STATUS_OK;
        unique case (ent.fmt)
            FMT_R: begin
                machine_word = {ent.f7, item.rs2, item.rs1, ent.f3, item.rd, ent.opc};
            end
            FMT_I: begin
                if (imm12_ok) begin
                    machine_word = {imm[11:0], item.rs1, ent.f3, item.rd, ent.opc};
                end else begin
                    status = STATUS_RANGE;
                end
            end
            FMT_S: begin
                if (imm12_ok) begin
                    machine_word = {imm[11:5], item.rs2, item.rs1, ent.f3, imm[4:0], ent.opc};
                end else begin
                    status = STATUS_RANGE;
                end
            end
            FMT_B: begin
                machine_word = {off[12], off[10:5], item.rs2, item.rs1, ent.f3,
                                off[4:1], off[11], ent.opc};
            end
            FMT_U: begin
                if (imm20_ok) begin
                    machine_word = {imm[19:0], item.rd, ent.opc};
                end else begin
                    status = STATUS_RANGE;
                end
            end
            FMT_J: begin
                machine_word = {off[20], off[10:1], off[11], off[19:12], item.rd, ent.opc};
            end
            default: begin
                status = STATUS_UNKNOWN;
            end
        endcase
    end

endmodule

FILE: rtl/core/riscv_instruction_encoder.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_func s_rd s_rs1 s_rs2 s_imm_value s_pc s_target_addr
// m_       out        m_valid / m_ready   m_machine_word m_status
//
// One request is accepted per cycle while s_ready is high; its result passes
// through the input register and then the result register before it is offered
// on m_. The encoder between them is a table lookup, one 32-bit subtract and
// field selection.
// Synchronous active-low reset empties both stages.
// When m_ready is low a held result stays put; one more request can still be
// taken into the input register before s_ready falls.

module riscv_instruction_encoder import rie_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_func,
    input  logic [4:0]  s_rd,
    input  logic [4:0]  s_rs1,
    input  logic [4:0]  s_rs2,
    input  logic [31:0] s_imm_value,
    input  logic [31:0] s_pc,
    input  logic [31:0] s_target_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_machine_word,
    output logic [1:0]  m_status
);

    item_t       in_item_reg;
    logic        in_valid_reg;
    logic [31:0] out_word_reg;
    status_t     out_status_reg;
    logic        out_valid_reg;

    logic        out_load;
    logic        in_load;
    logic [31:0] enc_word;
    status_t     enc_status;

    // Stage handshakes: the result register takes a new word when empty or drained.
    assign out_load = ~out_valid_reg | m_ready;
    assign s_ready  = ~in_valid_reg | out_load;
    assign in_load  = s_valid & s_ready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (in_load) begin
            in_item_reg <= '{func: s_func, rd: s_rd, rs1: s_rs1, rs2: s_rs2,
                             imm_value: s_imm_value, pc: s_pc,
                             target_addr: s_target_addr};
        end
    end

    rie_encode u_encode (
        .item         (in_item_reg),
        .machine_word (enc_word),
        .status       (enc_status)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
        if (out_load && in_valid_reg) begin
            out_word_reg   <= enc_word;
            out_status_reg <= enc_status;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_machine_word = out_word_reg;
    assign m_status       = out_status_reg;

endmodule

FILE: rtl/core/rie_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rie_checker import rie_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_machine_word,
    input logic [1:0]  m_status
);

    // A stalled result holds its value until taken.
    `RIE_ASSERT(a_hold_stall, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_machine_word) && $stable(m_status), "result changed while stalled")

    // Any error status comes with an all-zero word.
    `RIE_ASSERT(a_err_zero, aclk, aresetn, m_valid && (m_status != STATUS_OK) |-> (m_machine_word == 32'd0), "error result with nonzero word")

    // Only the three defined status codes appear.
    `RIE_ASSERT(a_status_code, aclk, aresetn, m_valid |-> (m_status == STATUS_OK) || (m_status == STATUS_RANGE) || (m_status == STATUS_UNKNOWN), "undefined status code")

    // Reset empties the result stage.
    `RIE_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind riscv_instruction_encoder rie_checker u_rie_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_machine_word (m_machine_word),
    .m_status       (m_status)
);
